/* rtl/limb_multiply_accumulate_top_defines.svh */
// assertion macros for the limb multiply-accumulate block
// used by limb_multiply_accumulate_top; no other dependencies
`ifndef LIMB_MULTIPLY_ACCUMULATE_TOP_DEFINES_SVH
`define LIMB_MULTIPLY_ACCUMULATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LMA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define LMA_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define LMA_ASSERT(lbl, clk, rstn, prop)
`define LMA_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

/* rtl/lma_pkg.sv */
// shared types and constants for the limb multiply-accumulate block
// no dependencies
package lma_pkg;

  localparam logic [1:0] MODE_MUL = 2'd0;
  localparam logic [1:0] MODE_ADD = 2'd1;
  localparam logic [1:0] MODE_SUB = 2'd2;

  localparam logic [1:0] CFG_MODE       = 2'd0;
  localparam logic [1:0] CFG_MULTIPLIER = 2'd1;
  localparam logic [1:0] CFG_CARRY_IN   = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } op_e;

  typedef struct packed {
    op_e  op;
    logic last;
    logic start;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* rtl/lma_front.sv */
// front end: accepts limb requests, decodes the mode and tracks run starts
// depends on lma_pkg
module lma_front #(
  parameter int unsigned LIMB_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [LIMB_WIDTH-1:0] first_limb_i,
  input  logic [LIMB_WIDTH-1:0] second_limb_i,
  input  logic                  last_i,
  input  logic [1:0]            mode_i,
  input  logic [LIMB_WIDTH-1:0] carry_in_i,
  input  lma_pkg::qstat_t       q_stat_i,
  output logic                  push_o,
  output logic [LIMB_WIDTH-1:0] mcand_o,
  output logic [LIMB_WIDTH-1:0] other_o,
  output logic [LIMB_WIDTH-1:0] init_o,
  output lma_pkg::ctrl_t        ctrl_o
);

  logic        run_start_q, run_start_d;
  logic        accept;
  lma_pkg::op_e op;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign push_o     = accept;

  always_comb begin
    case (mode_i)
      lma_pkg::MODE_ADD: op = lma_pkg::OP_ADD;
      lma_pkg::MODE_SUB: op = lma_pkg::OP_SUB;
      default:           op = lma_pkg::OP_MUL;
    endcase
  end

  assign mcand_o      = (op == lma_pkg::OP_MUL) ? first_limb_i : second_limb_i;
  assign other_o      = first_limb_i;
  assign init_o       = (op == lma_pkg::OP_MUL) ? carry_in_i : '0;
  assign ctrl_o.op    = op;
  assign ctrl_o.last  = last_i;
  assign ctrl_o.start = run_start_q;

  assign run_start_d = accept ? last_i : run_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_start_q <= 1'b1;
    end else begin
      run_start_q <= run_start_d;
    end
  end

endmodule

/* rtl/lma_queue.sv */
// short request queue between front end and arithmetic back end
// depends on lma_pkg
module lma_queue #(
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  pop_i,
  output logic [DATA_WIDTH-1:0] rdata_o,
  output lma_pkg::qstat_t       stat_o
);

  localparam int unsigned PW = lma_pkg::QPTR_W;
  localparam int unsigned CW = lma_pkg::QCNT_W;

  logic [DATA_WIDTH-1:0] mem_q [lma_pkg::QUEUE_DEPTH];
  logic [PW-1:0]         wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]         cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CW'(lma_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(lma_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(lma_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/lma_back.sv */
// back end: split multiply, product merge, carry-free pre-add and carry loop
// depends on lma_pkg
module lma_back #(
  parameter int unsigned LIMB_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lma_pkg::qstat_t       q_stat_i,
  output logic                  pop_o,
  input  logic [LIMB_WIDTH-1:0] mcand_i,
  input  logic [LIMB_WIDTH-1:0] other_i,
  input  logic [LIMB_WIDTH-1:0] init_i,
  input  lma_pkg::ctrl_t        ctrl_i,
  input  logic [LIMB_WIDTH-1:0] multiplier_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LIMB_WIDTH-1:0] result_limb_o,
  output logic [LIMB_WIDTH-1:0] carry_out_o,
  output logic                  last_out_o
);

  localparam int unsigned W    = LIMB_WIDTH;
  localparam int unsigned HALF = (LIMB_WIDTH + 1) / 2;
  localparam int unsigned PW   = 2 * HALF;
  localparam int unsigned FW   = 2 * PW;

  // handshake between stages
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  // stage 1: partial products
  logic [PW-1:0]  a_ext, b_ext;
  logic [PW-1:0]  p00_q, p01_q, p10_q, p11_q;
  logic [W-1:0]   s1_other_q, s1_init_q;
  lma_pkg::ctrl_t s1_ctrl_q;

  // stage 2: full product
  logic [FW-1:0]  prod;
  logic [W-1:0]   s2_lo_q, s2_hi_q, s2_other_q, s2_init_q;
  lma_pkg::ctrl_t s2_ctrl_q;

  // stage 3: addend or minuend folded in
  logic [W:0]     pre_sum;
  logic [W-1:0]   base_d, hi_adj_d;
  logic [W-1:0]   s3_base_q, s3_hi_q, s3_init_q;
  lma_pkg::ctrl_t s3_ctrl_q;

  // stage 4: running carry
  logic [W-1:0]   carry_q, carry_d, cin;
  logic [W:0]     acc;
  logic [W-1:0]   res_d;
  logic [W-1:0]   res_q, cout_q;
  logic           last_q;

  assign out_rdy = !out_v_q || !out_stall_i;
  assign s3_rdy  = !s3_v_q || out_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign pop_o   = s1_rdy && !q_stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      carry_q <= '0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= !q_stat_i.empty;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s3_v_q;
      end
      if (out_rdy && s3_v_q) begin
        carry_q <= carry_d;
      end
    end
  end

  assign a_ext = PW'(mcand_i);
  assign b_ext = PW'(multiplier_i);

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      p00_q      <= PW'(a_ext[HALF-1:0]) * PW'(b_ext[HALF-1:0]);
      p01_q      <= PW'(a_ext[HALF-1:0]) * PW'(b_ext[PW-1:HALF]);
      p10_q      <= PW'(a_ext[PW-1:HALF]) * PW'(b_ext[HALF-1:0]);
      p11_q      <= PW'(a_ext[PW-1:HALF]) * PW'(b_ext[PW-1:HALF]);
      s1_other_q <= other_i;
      s1_init_q  <= init_i;
      s1_ctrl_q  <= ctrl_i;
    end
  end

  assign prod = FW'(p00_q)
              + ((FW'(p01_q) + FW'(p10_q)) << HALF)
              + (FW'(p11_q) << PW);

  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      s2_lo_q    <= prod[W-1:0];
      s2_hi_q    <= prod[2*W-1:W];
      s2_other_q <= s1_other_q;
      s2_init_q  <= s1_init_q;
      s2_ctrl_q  <= s1_ctrl_q;
    end
  end

  always_comb begin
    pre_sum  = '0;
    base_d   = s2_lo_q;
    hi_adj_d = s2_hi_q;
    case (s2_ctrl_q.op)
      lma_pkg::OP_ADD: begin
        pre_sum  = {1'b0, s2_lo_q} + {1'b0, s2_other_q};
        base_d   = pre_sum[W-1:0];
        hi_adj_d = s2_hi_q + W'(pre_sum[W]);
      end
      lma_pkg::OP_SUB: begin
        pre_sum  = {1'b0, s2_other_q} - {1'b0, s2_lo_q};
        base_d   = pre_sum[W-1:0];
        hi_adj_d = s2_hi_q + W'(pre_sum[W]);
      end
      default: begin
        base_d   = s2_lo_q;
        hi_adj_d = s2_hi_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      s3_base_q <= base_d;
      s3_hi_q   <= hi_adj_d;
      s3_init_q <= s2_init_q;
      s3_ctrl_q <= s2_ctrl_q;
    end
  end

  // carry restarts on the first limb of a run
  assign cin = s3_ctrl_q.start ? s3_init_q : carry_q;

  always_comb begin
    if (s3_ctrl_q.op == lma_pkg::OP_SUB) begin
      acc = {1'b0, s3_base_q} - {1'b0, cin};
    end else begin
      acc = {1'b0, s3_base_q} + {1'b0, cin};
    end
    res_d   = acc[W-1:0];
    carry_d = s3_hi_q + W'(acc[W]);
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      res_q  <= res_d;
      cout_q <= s3_ctrl_q.last ? carry_d : '0;
      last_q <= s3_ctrl_q.last;
    end
  end

  assign out_valid_o   = out_v_q;
  assign result_limb_o = res_q;
  assign carry_out_o   = cout_q;
  assign last_out_o    = last_q;

endmodule

/* rtl/limb_multiply_accumulate_top.sv */
// top level of the limb multiply-accumulate block: config registers and wiring
// depends on lma_pkg, lma_front, lma_queue, lma_back and the defines header
//
// channel  direction  handshake                 payload
// in       request    in_valid_i / in_stall_o   first_limb_i, second_limb_i, last_i
// out      request    out_valid_o / out_stall_i result_limb_o, carry_out_o, last_out_o
// cfg      write      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one request per cycle sustained while out_stall_i is low; a result leaves once its
// request has passed the queue entry, two multiply stages, pre-add and carry add
// the carry add in the last stage is the only arithmetic loop between requests
// reset clears config registers, empties the two-entry queue and arms a run start
// out_stall_i holds a valid output register and backs up the pipeline into the queue;
// in_stall_o rises only when the queue is full
`include "limb_multiply_accumulate_top_defines.svh"

module limb_multiply_accumulate_top #(
  parameter int unsigned LIMB_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [LIMB_WIDTH-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [LIMB_WIDTH-1:0] first_limb_i,
  input  logic [LIMB_WIDTH-1:0] second_limb_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LIMB_WIDTH-1:0] result_limb_o,
  output logic [LIMB_WIDTH-1:0] carry_out_o,
  output logic                  last_out_o
);

  localparam int unsigned CTRL_W = $bits(lma_pkg::ctrl_t);
  localparam int unsigned QD_W   = CTRL_W + 3 * LIMB_WIDTH;

  logic [1:0]            mode_q;
  logic [LIMB_WIDTH-1:0] multiplier_q, carry_in_q;

  logic                  fe_push, be_pop;
  lma_pkg::qstat_t       q_stat;
  logic [LIMB_WIDTH-1:0] fe_mcand, fe_other, fe_init;
  lma_pkg::ctrl_t        fe_ctrl;
  logic [QD_W-1:0]       q_wdata, q_rdata;
  logic [LIMB_WIDTH-1:0] be_mcand, be_other, be_init;
  lma_pkg::ctrl_t        be_ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= lma_pkg::MODE_MUL;
      multiplier_q <= '0;
      carry_in_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lma_pkg::CFG_MODE:       mode_q       <= cfg_wdata_i[1:0];
        lma_pkg::CFG_MULTIPLIER: multiplier_q <= cfg_wdata_i;
        lma_pkg::CFG_CARRY_IN:   carry_in_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  lma_front #(
    .LIMB_WIDTH(LIMB_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .first_limb_i  (first_limb_i),
    .second_limb_i (second_limb_i),
    .last_i        (last_i),
    .mode_i        (mode_q),
    .carry_in_i    (carry_in_q),
    .q_stat_i      (q_stat),
    .push_o        (fe_push),
    .mcand_o       (fe_mcand),
    .other_o       (fe_other),
    .init_o        (fe_init),
    .ctrl_o        (fe_ctrl)
  );

  assign q_wdata = {fe_ctrl, fe_mcand, fe_other, fe_init};

  lma_queue #(
    .DATA_WIDTH(QD_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .wdata_i (q_wdata),
    .pop_i   (be_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  assign be_ctrl  = lma_pkg::ctrl_t'(q_rdata[QD_W-1:3*LIMB_WIDTH]);
  assign be_mcand = q_rdata[3*LIMB_WIDTH-1:2*LIMB_WIDTH];
  assign be_other = q_rdata[2*LIMB_WIDTH-1:LIMB_WIDTH];
  assign be_init  = q_rdata[LIMB_WIDTH-1:0];

  lma_back #(
    .LIMB_WIDTH(LIMB_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .pop_o         (be_pop),
    .mcand_i       (be_mcand),
    .other_i       (be_other),
    .init_i        (be_init),
    .ctrl_i        (be_ctrl),
    .multiplier_i  (multiplier_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_limb_o (result_limb_o),
    .carry_out_o   (carry_out_o),
    .last_out_o    (last_out_o)
  );

  `LMA_ASSERT(a_push_room, clk_i, rst_ni, fe_push |-> !q_stat.full)
  `LMA_ASSERT(a_pop_data, clk_i, rst_ni, be_pop |-> !q_stat.empty)
  `LMA_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, fe_push && !be_pop, !q_stat.empty)
  `LMA_ASSERT(a_carry_only_last, clk_i, rst_ni, (out_valid_o && !last_out_o) |-> (carry_out_o == '0))

endmodule
